### src/ffha_pkg.sv
`timescale 1ns / 1ps

package ffha_pkg;

	localparam int HEAP_WORDS_DEF = 1024;
	localparam int WORD_BYTES_DEF = 4;

	localparam int REQ_BYTES_W = 13;
	localparam int BLK_IDX_W   = 10;
	localparam int PIDX_W      = 10;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		STAT_OK   = 1'b0,
		STAT_FULL = 1'b1
	} status_t;

	typedef struct packed {
		op_t                    opcode;
		logic [REQ_BYTES_W-1:0] request_bytes;
		logic [BLK_IDX_W-1:0]   block_index;
	} req_t;

	typedef struct packed {
		logic [PIDX_W-1:0] payload_index;
		status_t           status;
	} res_t;

endpackage

### src/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps

// Free flips the sign of the block's header, unless its index is null or beyond the heap.
// Allocate walks the headers from word 0, merges each free header with the free headers
// after it inside the heap, tests it for fit and splits off the rest when there is room.
// The header store's single registered read port sets the pace.
// One request at a time; the result sits in an output register so the next request is
// taken while it waits. After reset S_INIT writes the initial free header, then ready.
module first_fit_heap_allocator_core #(
	parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
	parameter int WORD_BYTES = ffha_pkg::WORD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // request_bytes[12:0], block_index[22:13], zero pad
	input  logic [0:0]  s_tuser,   // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // payload_index[9:0], zero pad
	output logic [0:0]  m_tuser    // status[0]
);

	import ffha_pkg::*;

	localparam int AW    = $clog2(HEAP_WORDS);
	localparam int HDR_W = AW + 1;

	req_t             req;
	res_t             seq_res;
	logic             seq_res_valid;
	logic             seq_res_ready;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [HDR_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [HDR_W-1:0] mem_rdata;

	logic             m_tvalid_q;
	res_t             out_q;

	assign req = '{opcode:        op_t'(s_tuser[0]),
	               request_bytes: s_tdata[12:0],
	               block_index:   s_tdata[22:13]};

	// header chain: negative = free block of that many words, else allocated
	ffha_mem #(
		.DEPTH (HEAP_WORDS),
		.AW    (AW),
		.DW    (HDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ffha_seq #(
		.HEAP_WORDS (HEAP_WORDS),
		.WORD_BYTES (WORD_BYTES),
		.AW         (AW),
		.HDR_W      (HDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (seq_res_valid),
		.res_ready (seq_res_ready),
		.res       (seq_res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// output register: loads when empty or being drained this cycle
	assign seq_res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (seq_res_valid && seq_res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res_valid && seq_res_ready) begin
			out_q <= seq_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_q.payload_index};
	assign m_tuser  = out_q.status;

endmodule

### src/ffha_mem.sv
`timescale 1ns / 1ps

// Header store: one write port, one registered read port.
module ffha_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/ffha_seq.sv
`timescale 1ns / 1ps

// Walk sequencer: a shared adder steps the walk index, one header read per step.
module ffha_seq #(
	parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
	parameter int WORD_BYTES = ffha_pkg::WORD_BYTES_DEF,
	parameter int AW         = $clog2(HEAP_WORDS),
	parameter int HDR_W      = AW + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ffha_pkg::req_t   req,
	output logic             res_valid,
	input  logic             res_ready,
	output ffha_pkg::res_t   res,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [HDR_W-1:0] mem_wdata,
	output logic [AW-1:0]    mem_raddr,
	input  logic [HDR_W-1:0] mem_rdata
);

	import ffha_pkg::*;

	localparam int CW = (AW + 5 > 15) ? AW + 5 : 15;
	// ceil(x / WORD_BYTES) as ((x + WORD_BYTES - 1) * RECIP) >> SH, exact for x below 2**14
	localparam int SH = 17;
	localparam int unsigned RECIP = (2**SH + WORD_BYTES - 1) / WORD_BYTES;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_WAIT_H, S_HDR, S_MERGE, S_WAIT_M, S_MHDR,
		S_FIT, S_SPLIT, S_FWAIT, S_FNEG, S_DONE
	} state_t;

	state_t                 state_q;
	logic [AW-1:0]          i_q;
	logic [AW-1:0]          addr_q;
	logic [AW:0]            s_q;
	logic [REQ_BYTES_W-1:0] ni_q;
	logic [REQ_BYTES_W-1:0] nbytes_q;
	res_t                   res_q;

	logic [13:0]   nb_round;
	logic [31:0]   ni_prod;
	logic          hdr_neg;
	logic [AW:0]   mag;
	logic [CW-1:0] step_opnd;
	logic [CW-1:0] sum;
	logic [CW-1:0] merged;
	logic          merge_ok;
	logic          fits;
	logic          split;

	assign nb_round = 14'(req.request_bytes) + 14'(WORD_BYTES - 1);
	assign ni_prod  = 32'(nb_round) * 32'(RECIP);

	assign hdr_neg = mem_rdata[HDR_W-1];
	assign mag     = -mem_rdata;

	// shared adder: i + 1 + size (header in S_HDR, block size otherwise)
	assign step_opnd = (state_q == S_HDR) ? CW'(mem_rdata) : CW'(s_q);
	assign sum       = CW'(i_q) + CW'(1) + step_opnd;

	assign merged   = CW'(s_q) + CW'(1) + CW'(mag);
	assign merge_ok = hdr_neg && (sum + CW'(1) + CW'(mag) <= CW'(HEAP_WORDS));
	assign fits     = (sum <= CW'(HEAP_WORDS)) &&
	                  (CW'(s_q) * CW'(WORD_BYTES) >= CW'(nbytes_q));
	assign split    = CW'(s_q) >= CW'(ni_q) + CW'(2);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign mem_raddr = addr_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = HDR_W'(CW'(0) - merged);
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = HDR_W'(1 - HEAP_WORDS);
			end
			S_MHDR: begin
				mem_we = merge_ok;
			end
			S_FIT: begin
				mem_we = fits;
				if (split) begin
					mem_waddr = AW'(CW'(i_q) + CW'(1) + CW'(ni_q));
					mem_wdata = HDR_W'(CW'(ni_q) + CW'(1) - CW'(s_q));
				end else begin
					mem_wdata = HDR_W'(s_q);
				end
			end
			S_SPLIT: begin
				mem_we    = 1'b1;
				mem_wdata = HDR_W'(ni_q);
			end
			S_FNEG: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = -mem_rdata;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			i_q      <= '0;
			addr_q   <= '0;
			s_q      <= '0;
			ni_q     <= '0;
			nbytes_q <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						nbytes_q <= req.request_bytes;
						ni_q     <= ni_prod[SH +: REQ_BYTES_W];
						res_q    <= '{payload_index: '0, status: STAT_OK};
						if (req.opcode == OP_ALLOC) begin
							i_q     <= '0;
							addr_q  <= '0;
							state_q <= S_WAIT_H;
						end else if (req.block_index != '0 &&
						             CW'(req.block_index) <= CW'(HEAP_WORDS)) begin
							addr_q  <= AW'(CW'(req.block_index) - CW'(1));
							state_q <= S_FWAIT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_WAIT_H: begin
					state_q <= S_HDR;
				end
				S_HDR: begin
					if (hdr_neg) begin
						s_q     <= mag;
						state_q <= S_MERGE;
					end else if (sum >= CW'(HEAP_WORDS)) begin
						res_q   <= '{payload_index: '0, status: STAT_FULL};
						state_q <= S_DONE;
					end else begin
						i_q     <= AW'(sum);
						addr_q  <= AW'(sum);
						state_q <= S_WAIT_H;
					end
				end
				S_MERGE: begin
					if (sum >= CW'(HEAP_WORDS)) begin
						state_q <= S_FIT;
					end else begin
						addr_q  <= AW'(sum);
						state_q <= S_WAIT_M;
					end
				end
				S_WAIT_M: begin
					state_q <= S_MHDR;
				end
				S_MHDR: begin
					if (merge_ok) begin
						s_q     <= (AW+1)'(merged);
						state_q <= S_MERGE;
					end else begin
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					if (fits) begin
						res_q   <= '{payload_index: PIDX_W'(CW'(i_q) + CW'(1)),
						             status: STAT_OK};
						state_q <= split ? S_SPLIT : S_DONE;
					end else if (sum >= CW'(HEAP_WORDS)) begin
						res_q   <= '{payload_index: '0, status: STAT_FULL};
						state_q <= S_DONE;
					end else begin
						i_q     <= AW'(sum);
						addr_q  <= AW'(sum);
						state_q <= S_WAIT_H;
					end
				end
				S_SPLIT: begin
					state_q <= S_DONE;
				end
				S_FWAIT: begin
					state_q <= S_FNEG;
				end
				S_FNEG: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import ffha_pkg::*;

	localparam int HEAP_WORDS = HEAP_WORDS_DEF;
	localparam int WORD_BYTES = WORD_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1550;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_PRINTS = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;

	first_fit_heap_allocator_core #(
		.HEAP_WORDS(HEAP_WORDS),
		.WORD_BYTES(WORD_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow heap: headers as signed words, plus which words have ever been written
	int   heap_hdr [0:HEAP_WORDS-1];
	bit   hdr_written [0:HEAP_WORDS-1];
	res_t pending_results [$];
	int   live_blocks [$];
	int   freed_blocks [$];

	bit no_idle = 1'b0;
	int errors = 0;
	int results_seen = 0;
	int n_alloc_ok = 0, n_alloc_fail = 0, n_free = 0, n_null = 0;
	int n_merge = 0, n_split = 0, n_whole = 0;

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_bytes();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 0;
		else if (r < 60)
			return $urandom_range(1, 64);
		else if (r < 90)
			return $urandom_range(65, 512);
		else if (r < 98)
			return $urandom_range(513, 4092);
		return $urandom_range(4093, 4096);
	endfunction

	// a random payload index whose header word (not the heap's last word) has been written since reset
	function automatic int pick_written();
		int w;
		do
			w = $urandom_range(0, HEAP_WORDS - 2);
		while (!hdr_written[w]);
		return w + 1;
	endfunction

	function automatic void set_hdr(int idx, int val);
		heap_hdr[idx] = val;
		hdr_written[idx] = 1'b1;
	endfunction

	function automatic void reset_heap();
		for (int k = 0; k < HEAP_WORDS; k++) begin
			heap_hdr[k] = 0;
			hdr_written[k] = 1'b0;
		end
		set_hdr(0, 1 - HEAP_WORDS);
	endfunction

	// first-fit walk from word 0, coalescing free neighbours before each fit test
	function automatic res_t predict_alloc(int nbytes);
		int   i, s, nx, merged, ni;
		res_t r;
		r.payload_index = '0;
		r.status = STAT_FULL;
		i = 0;
		while (i < HEAP_WORDS) begin
			if (heap_hdr[i] < 0) begin
				s = -heap_hdr[i];
				while (1) begin
					nx = i + 1 + s;
					if (nx >= HEAP_WORDS || heap_hdr[nx] >= 0)
						break;
					merged = s + 1 - heap_hdr[nx];
					if (i + 1 + merged > HEAP_WORDS)
						break;
					s = merged;
					set_hdr(i, -s);
					n_merge++;
				end
				if (i + 1 + s <= HEAP_WORDS && s * WORD_BYTES >= nbytes) begin
					ni = (nbytes + WORD_BYTES - 1) / WORD_BYTES;
					if (s >= ni + 2) begin
						set_hdr(i + 1 + ni, -(s - ni - 1));
						set_hdr(i, ni);
						n_split++;
					end else begin
						set_hdr(i, s);
						n_whole++;
					end
					r.payload_index = PIDX_W'(i + 1);
					r.status = STAT_OK;
					return r;
				end
				i += 1 + s;
			end else begin
				i += 1 + heap_hdr[i];
			end
		end
		return r;
	endfunction

	// free flips the header sign, nothing more
	function automatic res_t predict_free(int bidx);
		res_t r;
		if (bidx != 0 && bidx - 1 < HEAP_WORDS)
			heap_hdr[bidx - 1] = -heap_hdr[bidx - 1];
		r.payload_index = '0;
		r.status = STAT_OK;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (errors < MAX_PRINTS)
			$display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	// one request: hold it until taken, predict on acceptance, then maybe idle
	task automatic send_request(op_t op, int nbytes, int bidx, output res_t r);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, BLK_IDX_W'(bidx), REQ_BYTES_W'(nbytes)};
		do
			@(posedge clk);
		while (!s_tready);
		if (op == OP_ALLOC)
			r = predict_alloc(nbytes);
		else
			r = predict_free(bidx);
		pending_results.push_back(r);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic do_alloc(int nbytes, int junk_idx);
		res_t r;
		send_request(OP_ALLOC, nbytes, junk_idx, r);
		if (r.status == STAT_OK) begin
			live_blocks.push_back(int'(r.payload_index));
			n_alloc_ok++;
		end else begin
			n_alloc_fail++;
		end
	endtask

	task automatic do_free(int bidx);
		res_t r;
		send_request(OP_FREE, $urandom_range(0, 4096), bidx, r);
		for (int k = 0; k < live_blocks.size(); k++)
			if (live_blocks[k] == bidx) begin
				live_blocks.delete(k);
				freed_blocks.push_back(bidx);
				break;
			end
		if (bidx == 0)
			n_null++;
		else
			n_free++;
	endtask

	// result checker with random back-pressure
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		int g;
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, payload_index", m_tdata[PIDX_W-1:0], -1);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[PIDX_W-1:0] !== want.payload_index)
						report_mismatch("payload_index", m_tdata[PIDX_W-1:0],
							want.payload_index);
					if (m_tuser[0] !== want.status)
						report_mismatch("status", m_tuser[0], want.status);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				g = pick_gap();
				if (g > 0) begin
					stall_left = g - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// corner requests: empty heap, extremes of size, null and stray frees
	task automatic test_directed();
		do_alloc(0, 1023);      // zero-byte request splits off an empty block
		do_alloc(4096, 0);      // larger than any block the heap can hold
		do_alloc(4092, 512);    // the rest is one word short
		do_free(1);             // freeing an empty block leaves it allocated
		do_free(0);             // null
		do_alloc(1, 0);
		do_alloc(5, 0);
		do_alloc(8, 0);
		do_free(4);
		do_free(7);
		do_alloc(20, 0);        // coalesces the two freed blocks and the tail
		do_free(4);             // releases the block just carved out
		do_free(2);
		do_alloc(4, 0);         // one-word hole coalesces with its free neighbours
		do_free(pick_written()); // stray free of some written word
		do_alloc(4093, 0);
		do_alloc(2000, 0);
		do_alloc(2000, 0);
		do_alloc(3, 0);
		while (live_blocks.size() > 0)
			do_free(live_blocks[0]);
		do_alloc(4092, 0);
		do_alloc(4088, 0);
	endtask

	// alternating fill-heavy and drain-heavy stretches of random traffic
	task automatic test_random_churn();
		int n, r, k;
		bit fill;
		n = 0;
		while (n < RANDOM_ITEMS) begin
			fill = ((n / 200) % 2) == 0;
			no_idle = (n >= 600 && n < 750);
			r = $urandom_range(0, 99);
			if (r >= (fill ? 75 : 35) && r < (fill ? 90 : 88) && live_blocks.size() == 0)
				r = 0;
			if (r < (fill ? 75 : 35)) begin
				do_alloc(pick_bytes(), $urandom_range(0, 1023));
				n++;
			end else if (r < (fill ? 90 : 88)) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				do_free(live_blocks[k]);
				n++;
			end else if (r < (fill ? 93 : 92)) begin
				do_free(0);
			end else begin
				if (freed_blocks.size() > 0 && $urandom_range(0, 1) == 0)
					do_free(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
				else
					do_free(pick_written());
				n++;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		reset_heap();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_churn();
		s_tvalid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered: %0d allocations (%0d refused), %0d frees, %0d null frees",
			n_alloc_ok, n_alloc_fail, n_free, n_null);
		$display("covered: %0d coalesces, %0d splits, %0d whole takes, %0d results checked",
			n_merge, n_split, n_whole, results_seen);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#300_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

### sim.f
src/ffha_pkg.sv
src/ffha_mem.sv
src/ffha_seq.sv
src/first_fit_heap_allocator_core.sv
dv/tb.sv
